// ===== sv/mhpq_pkg.sv =====
// mhpq_pkg: types and constants shared by the min-heap priority queue.
// Used by mhpq_cell and min_heap_priority_queue; depends on nothing.
package mhpq_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned KEY_W        = 32;
  localparam int unsigned OCC_W        = 5;

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } op_e_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef struct packed {
    op_e_t                     opcode;
    logic signed [KEY_W-1:0]   value;
  } req_t;

  typedef struct packed {
    logic signed [KEY_W-1:0]   result_value;
    status_t                   status;
    logic [OCC_W-1:0]          occupancy;
  } rsp_t;

  // control broadcast along the cell row
  typedef struct packed {
    logic  act;
    op_e_t op;
  } cell_ctl_t;

endpackage

// ===== sv/min_heap_priority_queue.sv =====
// min_heap_priority_queue: bounded min-priority queue built as a sorted cell row.
// Depends on mhpq_pkg and mhpq_cell.
//
// Usage notes
// - Request channel: drive in_req {opcode, value} with start high; the request
//   is taken on a rising edge where start is high and busy is low.
//   opcode insert stores value, opcode extract removes the smallest key.
// - Result channel: out_valid pulses for one cycle with out_rsp holding
//   {result_value, status, occupancy}. No back-pressure is possible, so the
//   result must be captured in that cycle.
// - Sequencing: an accepted request is held in the request register; then one
//   parallel update of the cell row, which keeps the row sorted ascending, and
//   the result register out_rsp/out_valid are written together. busy is high
//   while a request is held, so no new request is taken until the held one
//   has been processed.
// - Status: full on insert into a full queue (value dropped), empty on
//   extract from an empty queue (result_value zero), ok otherwise.
// - Reset (synchronous, active low) empties the queue; cell contents are
//   left as they are and only become meaningful once written.
module min_heap_priority_queue #(
  parameter int unsigned CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  mhpq_pkg::req_t in_req,
  output logic           out_valid,
  output mhpq_pkg::rsp_t out_rsp
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // request holding register
  logic           pend_r, pend_nxt;
  mhpq_pkg::req_t req_r, req_nxt;

  // occupancy
  logic [CNT_W-1:0] count_r, count_nxt;

  // result register
  logic           out_valid_r, out_valid_nxt;
  mhpq_pkg::rsp_t out_rsp_r, out_rsp_nxt;

  logic is_full, is_empty;
  mhpq_pkg::cell_ctl_t ctl;

  // cell row wiring
  logic signed [mhpq_pkg::KEY_W-1:0] cell_val [CAPACITY];
  logic                              cell_gt  [CAPACITY];

  assign busy      = pend_r;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  assign is_full  = (count_r == CNT_W'(CAPACITY));
  assign is_empty = (count_r == '0);

  // rejected requests leave the row untouched
  always_comb begin
    ctl.op  = req_r.opcode;
    ctl.act = pend_r &&
              !((req_r.opcode == mhpq_pkg::OP_INSERT)  && is_full) &&
              !((req_r.opcode == mhpq_pkg::OP_EXTRACT) && is_empty);
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic signed [mhpq_pkg::KEY_W-1:0] lv;
      logic                              lg;
      logic signed [mhpq_pkg::KEY_W-1:0] rv;
      logic                              occ;

      assign occ = (count_r > CNT_W'(gi));

      if (gi == 0) begin : g_head
        assign lv = req_r.value;
        assign lg = 1'b0;
      end else begin : g_body
        assign lv = cell_val[gi-1];
        assign lg = cell_gt[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_tail
        assign rv = cell_val[gi];
      end else begin : g_mid
        assign rv = cell_val[gi+1];
      end

      mhpq_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .key       (req_r.value),
        .occupied  (occ),
        .left_val  (lv),
        .left_gt   (lg),
        .right_val (rv),
        .val       (cell_val[gi]),
        .gt        (cell_gt[gi])
      );
    end
  endgenerate

  // request, count and result next state
  always_comb begin
    pend_nxt      = pend_r;
    req_nxt       = req_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = out_rsp_r;

    if (start && !busy) begin
      pend_nxt = 1'b1;
      req_nxt  = in_req;
    end

    if (pend_r) begin
      pend_nxt                 = 1'b0;
      out_valid_nxt            = 1'b1;
      out_rsp_nxt.result_value = '0;
      unique case (req_r.opcode)
        mhpq_pkg::OP_INSERT: begin
          if (is_full) begin
            out_rsp_nxt.status = mhpq_pkg::ST_FULL;
          end else begin
            out_rsp_nxt.status = mhpq_pkg::ST_OK;
            count_nxt          = count_r + 1'b1;
          end
        end
        mhpq_pkg::OP_EXTRACT: begin
          if (is_empty) begin
            out_rsp_nxt.status = mhpq_pkg::ST_EMPTY;
          end else begin
            out_rsp_nxt.status       = mhpq_pkg::ST_OK;
            out_rsp_nxt.result_value = cell_val[0];
            count_nxt                = count_r - 1'b1;
          end
        end
        default: out_rsp_nxt.status = mhpq_pkg::ST_OK;
      endcase
      out_rsp_nxt.occupancy = mhpq_pkg::OCC_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |=> out_valid_r)
    else $error("pending request gave no result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("occupancy beyond capacity");

  a_full_reported: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && (req_r.opcode == mhpq_pkg::OP_INSERT) && is_full)
      |=> (out_rsp_r.status == mhpq_pkg::ST_FULL) && (count_r == CNT_W'(CAPACITY)))
    else $error("insert into full queue not reported");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_rsp_r.status != mhpq_pkg::ST_OK)) |-> (out_rsp_r.result_value == '0))
    else $error("rejected request carries a value");

  if (CAPACITY >= 2) begin : g_sort_chk
    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
      (count_r >= CNT_W'(2)) |-> !(cell_val[0] > cell_val[1]))
      else $error("cell row out of order at head");
  end

endmodule

// ===== sv/mhpq_cell.sv =====
// mhpq_cell: one slot of the sorted cell row.
// Depends on mhpq_pkg.
module mhpq_cell (
  input  logic                                clk,
  input  mhpq_pkg::cell_ctl_t                 ctl,
  input  logic signed [mhpq_pkg::KEY_W-1:0]   key,
  input  logic                                occupied,
  input  logic signed [mhpq_pkg::KEY_W-1:0]   left_val,
  input  logic                                left_gt,
  input  logic signed [mhpq_pkg::KEY_W-1:0]   right_val,
  output logic signed [mhpq_pkg::KEY_W-1:0]   val,
  output logic                                gt
);

  logic signed [mhpq_pkg::KEY_W-1:0] val_r;
  logic signed [mhpq_pkg::KEY_W-1:0] val_nxt;

  // empty slots count as greater than any key
  assign gt  = !occupied || (val_r > key);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.act) begin
      unique case (ctl.op)
        mhpq_pkg::OP_EXTRACT: val_nxt = right_val;
        mhpq_pkg::OP_INSERT: begin
          if (gt) begin
            val_nxt = left_gt ? left_val : key;
          end
        end
        default: val_nxt = val_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule
